// ===== hdl/nhr_broadcast_step_schedule_macros.svh =====
// ----------------------------------------------------------------------------
// Broadcast step schedule assertion macros
// Shared concurrent assertion forms, clocked on clk_i and gated by rst_ni.
// ----------------------------------------------------------------------------
`ifndef NHR_BROADCAST_STEP_SCHEDULE_MACROS_SVH
`define NHR_BROADCAST_STEP_SCHEDULE_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define NHR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define NHR_ASSERT_NEVER(lbl, cond, msg) \
  `NHR_ASSERT(lbl, !(cond), msg)

`endif

// ===== hdl/nhr_pkg.sv =====
// ----------------------------------------------------------------------------
// Broadcast step schedule package
// Field widths, register indexes, shared-unit opcodes and the decode record.
// ----------------------------------------------------------------------------
package nhr_pkg;

  // Field widths.
  localparam int STEP_W     = 4;
  localparam int RANK_W     = 7;
  localparam int IDX_W      = 6;
  localparam int TOTAL_W    = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // At most this many beats are emitted for one step.
  localparam int MAX_RESULTS = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_RANK_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SELF_RANK  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_RANK  = 2'd2;

  // Register values after reset.
  localparam logic [RANK_W-1:0] RANK_COUNT_RST = 7'd2;

  // Operations of the shared modular add/subtract unit.
  typedef enum logic {
    MOD_ADD,
    MOD_SUB
  } mod_op_e;

  // Decoded step: distance k = 2^sh, sender count m and slice count n.
  typedef struct packed {
    logic              err;
    logic              phase;
    logic [RANK_W-1:0] k;
    logic [RANK_W-1:0] m;
    logic [RANK_W-1:0] n;
  } dec_t;

endpackage

// ===== hdl/nhr_step_if.sv =====
// ----------------------------------------------------------------------------
// Step request channel
// Valid/ready channel that carries one step index per beat.
// ----------------------------------------------------------------------------
interface nhr_step_if;
  logic                      valid;
  logic                      ready;
  logic [nhr_pkg::STEP_W-1:0] step_index;

  modport source (output valid, output step_index, input ready);
  modport sink   (input valid, input step_index, output ready);
endinterface

// ===== hdl/nhr_result_if.sv =====
// ----------------------------------------------------------------------------
// Schedule result channel
// Valid/ready channel that carries one slice transfer descriptor per beat.
// ----------------------------------------------------------------------------
interface nhr_result_if;
  logic                        valid;
  logic                        ready;
  logic                        phase;
  logic [nhr_pkg::RANK_W-1:0]  to_peer;
  logic [nhr_pkg::RANK_W-1:0]  from_peer;
  logic [nhr_pkg::IDX_W-1:0]   tx_slice;
  logic [nhr_pkg::IDX_W-1:0]   rx_slice;
  logic                        tx_valid;
  logic                        rx_valid;
  logic [nhr_pkg::TOTAL_W-1:0] slice_total;
  logic                        is_last;
  logic                        error;

  modport source (
    output valid, output phase, output to_peer, output from_peer,
    output tx_slice, output rx_slice, output tx_valid, output rx_valid,
    output slice_total, output is_last, output error,
    input ready
  );
  modport sink (
    input valid, input phase, input to_peer, input from_peer,
    input tx_slice, input rx_slice, input tx_valid, input rx_valid,
    input slice_total, input is_last, input error,
    output ready
  );
endinterface

// ===== hdl/nhr_mod_unit.sv =====
// ----------------------------------------------------------------------------
// Modular add/subtract unit
// Computes (a + b) mod r or (a - b) mod r for operands already below r.
// ----------------------------------------------------------------------------
module nhr_mod_unit (
  input  nhr_pkg::mod_op_e            op_i,
  input  logic [nhr_pkg::RANK_W-1:0]  a_i,
  input  logic [nhr_pkg::RANK_W-1:0]  b_i,
  input  logic [nhr_pkg::RANK_W-1:0]  r_i,
  output logic [nhr_pkg::RANK_W-1:0]  y_o
);

  logic [nhr_pkg::RANK_W:0] sum;
  logic [nhr_pkg::RANK_W:0] diff;
  logic [nhr_pkg::RANK_W:0] r_ext;

  assign r_ext = {1'b0, r_i};
  assign sum   = {1'b0, a_i} + {1'b0, b_i};
  assign diff  = {1'b0, a_i} - {1'b0, b_i};

  // One correction step: the raw result lies within one modulus of range.
  always_comb begin
    unique case (op_i)
      nhr_pkg::MOD_ADD: begin
        if (sum >= r_ext) begin
          y_o = nhr_pkg::RANK_W'(sum - r_ext);
        end else begin
          y_o = sum[nhr_pkg::RANK_W-1:0];
        end
      end
      default: begin
        if (diff[nhr_pkg::RANK_W]) begin
          y_o = nhr_pkg::RANK_W'(diff + r_ext);
        end else begin
          y_o = diff[nhr_pkg::RANK_W-1:0];
        end
      end
    endcase
  end

endmodule

// ===== hdl/nhr_step_decode.sv =====
// ----------------------------------------------------------------------------
// Step decoder
// Checks a request and derives phase, peer distance, sender count and the
// number of slices moved in the step.
// ----------------------------------------------------------------------------
module nhr_step_decode #(
  parameter int MAX_RANKS = 64
) (
  input  logic [nhr_pkg::RANK_W-1:0] rank_count_i,
  input  logic [nhr_pkg::IDX_W-1:0]  self_rank_i,
  input  logic [nhr_pkg::IDX_W-1:0]  root_rank_i,
  input  logic [nhr_pkg::STEP_W-1:0] step_i,
  output nhr_pkg::dec_t              dec_o
);

  logic [nhr_pkg::RANK_W-1:0] rm1;
  logic [2:0]                 lg;
  logic [nhr_pkg::STEP_W-1:0] two_lg;
  logic                       scatter;
  logic [2:0]                 sh;
  logic [nhr_pkg::RANK_W-1:0] k;
  logic [nhr_pkg::RANK_W:0]   span;
  logic                       pow2;
  logic                       last_sc;

  assign rm1 = rank_count_i - 7'd1;

  // Ceiling log2 of the rank count: the bit length of rank_count - 1.
  always_comb begin
    lg = 3'd0;
    for (int i = 0; i < nhr_pkg::RANK_W; i++) begin
      if (rm1[i]) begin
        lg = 3'(i + 1);
      end
    end
  end

  assign two_lg  = {lg, 1'b0};
  assign scatter = step_i < {1'b0, lg};

  // Scatter distance doubles each step; allgather distance halves.
  assign sh   = scatter ? step_i[2:0] : 3'(two_lg - 4'd1 - step_i);
  assign k    = 7'd1 << sh;
  assign span = {1'b0, rm1} + {1'b0, k};

  assign pow2    = (rank_count_i & rm1) == 7'd0;
  assign last_sc = scatter && (step_i == ({1'b0, lg} - 4'd1));

  always_comb begin
    dec_o.err   = (rank_count_i < 7'd2) || (32'(rank_count_i) > MAX_RANKS) ||
                  ({1'b0, self_rank_i} >= rank_count_i) ||
                  ({1'b0, root_rank_i} >= rank_count_i) ||
                  (step_i >= two_lg);
    dec_o.phase = !scatter;
    dec_o.k     = k;
    dec_o.m     = (!pow2 && last_sc) ? (rank_count_i - k) : k;
    dec_o.n     = nhr_pkg::RANK_W'(span >> ({1'b0, sh} + 4'd1));
  end

endmodule

// ===== hdl/nhr_broadcast_step_schedule.sv =====
// ----------------------------------------------------------------------------
// Broadcast step schedule
// Turns a scatter/allgather step index into per-slice transfer beats for
// this rank, using one shared modular add/subtract unit under a sequencer.
// ----------------------------------------------------------------------------
// Sequence: after a step is accepted it is decoded, then the four modular setup ops
// (root distance, minus, plus, delta) run on the shared unit before the first beat is
// offered; a bad request goes from decode straight to its single error beat. Once a
// beat is taken and more remain, the tx and rx slice cursors are stepped one after the
// other on that unit. A new step is taken only in idle, after the last beat is taken.
// Reset: rank_count = 2, self_rank = 0, root_rank = 0, sequencer idle.
module nhr_broadcast_step_schedule #(
  parameter int MAX_RANKS = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  nhr_step_if.sink                         step_i,
  nhr_result_if.source                     result_o,
  input  logic                             cfg_we_i,
  input  logic [nhr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [nhr_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_DECODE  = 4'd1;
  localparam logic [3:0] ST_DROOT   = 4'd2;
  localparam logic [3:0] ST_MINUS   = 4'd3;
  localparam logic [3:0] ST_PLUS    = 4'd4;
  localparam logic [3:0] ST_DLT     = 4'd5;
  localparam logic [3:0] ST_EMIT    = 4'd6;
  localparam logic [3:0] ST_NEXT_TX = 4'd7;
  localparam logic [3:0] ST_NEXT_RX = 4'd8;

  localparam int RW = nhr_pkg::RANK_W;
  localparam int TW = nhr_pkg::TOTAL_W;

  // Configuration registers.
  logic [RW-1:0]            rank_q;
  logic [nhr_pkg::IDX_W-1:0] self_q;
  logic [nhr_pkg::IDX_W-1:0] root_q;

  // Sequencer control.
  logic [3:0]    state_q, state_d;
  logic [TW-1:0] rem_q, rem_d;

  // Working and result registers.
  logic [nhr_pkg::STEP_W-1:0] step_q, step_d;
  nhr_pkg::dec_t              dec_q, dec_d;
  logic [RW-1:0]              droot_q, droot_d;
  logic [RW-1:0]              minus_q, minus_d;
  logic [RW-1:0]              plus_q, plus_d;
  logic [RW-1:0]              dlt_q, dlt_d;
  logic [RW-1:0]              txs_q, txs_d;
  logic [RW-1:0]              rxs_q, rxs_d;
  logic [RW-1:0]              to_q, to_d;
  logic [RW-1:0]              from_q, from_d;
  logic                       phase_q, phase_d;
  logic                       txv_q, txv_d;
  logic                       rxv_q, rxv_d;
  logic                       err_q, err_d;
  logic [TW-1:0]              total_q, total_d;

  nhr_pkg::dec_t    dec;
  nhr_pkg::mod_op_e mu_op;
  logic [RW-1:0]    mu_a;
  logic [RW-1:0]    mu_b;
  logic [RW-1:0]    mu_y;
  logic [RW-1:0]    self_ext;
  logic             sc_tx;
  logic             sc_rx;
  logic [RW-1:0]    n_sel;

  assign self_ext = {1'b0, self_q};

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q <= nhr_pkg::RANK_COUNT_RST;
      self_q <= '0;
      root_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        nhr_pkg::CFG_RANK_COUNT: rank_q <= cfg_data_i;
        nhr_pkg::CFG_SELF_RANK:  self_q <= cfg_data_i[nhr_pkg::IDX_W-1:0];
        nhr_pkg::CFG_ROOT_RANK:  root_q <= cfg_data_i[nhr_pkg::IDX_W-1:0];
        default: ;
      endcase
    end
  end

  nhr_step_decode #(
    .MAX_RANKS (MAX_RANKS)
  ) u_decode (
    .rank_count_i (rank_q),
    .self_rank_i  (self_q),
    .root_rank_i  (root_q),
    .step_i       (step_q),
    .dec_o        (dec)
  );

  // Operand selection for the shared modular unit.
  always_comb begin
    mu_op = nhr_pkg::MOD_SUB;
    mu_a  = self_ext;
    mu_b  = dec_q.k;
    unique case (state_q)
      ST_DROOT: begin
        mu_a = {1'b0, root_q};
        mu_b = self_ext;
      end
      ST_PLUS: begin
        mu_op = nhr_pkg::MOD_ADD;
      end
      ST_DLT: begin
        mu_op = nhr_pkg::MOD_ADD;
        mu_a  = dec_q.k;
      end
      ST_NEXT_TX: begin
        mu_a = txs_q;
        mu_b = dlt_q;
      end
      ST_NEXT_RX: begin
        mu_a = rxs_q;
        mu_b = dlt_q;
      end
      default: ;
    endcase
  end

  nhr_mod_unit u_mod (
    .op_i (mu_op),
    .a_i  (mu_a),
    .b_i  (mu_b),
    .r_i  (rank_q),
    .y_o  (mu_y)
  );

  // Scatter role: sender if the root distance is below m, receiver if it
  // lies in the next m ranks past the current distance.
  assign sc_tx = droot_q < dec_q.m;
  assign sc_rx = !sc_tx && (droot_q >= dec_q.k) &&
                 ({1'b0, droot_q} < ({1'b0, dec_q.m} + {1'b0, dec_q.k}));
  assign n_sel = (dec_q.phase || sc_tx || sc_rx) ? dec_q.n : '0;

  // Sequencer next-state and datapath updates.
  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    step_d  = step_q;
    dec_d   = dec_q;
    droot_d = droot_q;
    minus_d = minus_q;
    plus_d  = plus_q;
    dlt_d   = dlt_q;
    txs_d   = txs_q;
    rxs_d   = rxs_q;
    to_d    = to_q;
    from_d  = from_q;
    phase_d = phase_q;
    txv_d   = txv_q;
    rxv_d   = rxv_q;
    err_d   = err_q;
    total_d = total_q;
    unique case (state_q)
      ST_IDLE: begin
        if (step_i.valid) begin
          step_d  = step_i.step_index;
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        dec_d = dec;
        if (dec.err) begin
          phase_d = 1'b0;
          to_d    = rank_q;
          from_d  = rank_q;
          txv_d   = 1'b0;
          rxv_d   = 1'b0;
          err_d   = 1'b1;
          total_d = '0;
          rem_d   = TW'(1);
          state_d = ST_EMIT;
        end else begin
          state_d = ST_DROOT;
        end
      end
      ST_DROOT: begin
        droot_d = mu_y;
        state_d = ST_MINUS;
      end
      ST_MINUS: begin
        minus_d = mu_y;
        state_d = ST_PLUS;
      end
      ST_PLUS: begin
        plus_d  = mu_y;
        state_d = ST_DLT;
      end
      ST_DLT: begin
        dlt_d   = mu_y;
        phase_d = dec_q.phase;
        err_d   = 1'b0;
        total_d = n_sel[TW-1:0];
        if (n_sel == '0) begin
          rem_d = TW'(1);
        end else if (32'(n_sel) > nhr_pkg::MAX_RESULTS) begin
          rem_d = TW'(nhr_pkg::MAX_RESULTS);
        end else begin
          rem_d = n_sel[TW-1:0];
        end
        if (dec_q.phase) begin
          to_d   = plus_q;
          from_d = minus_q;
          txs_d  = self_ext;
          rxs_d  = minus_q;
          txv_d  = 1'b1;
          rxv_d  = 1'b1;
        end else begin
          to_d   = sc_tx ? minus_q : rank_q;
          from_d = sc_rx ? plus_q : rank_q;
          txs_d  = minus_q;
          rxs_d  = self_ext;
          txv_d  = sc_tx;
          rxv_d  = sc_rx;
        end
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (result_o.ready) begin
          if (rem_q == TW'(1)) begin
            state_d = ST_IDLE;
          end else begin
            rem_d   = rem_q - TW'(1);
            state_d = ST_NEXT_TX;
          end
        end
      end
      ST_NEXT_TX: begin
        txs_d   = mu_y;
        state_d = ST_NEXT_RX;
      end
      ST_NEXT_RX: begin
        rxs_d   = mu_y;
        state_d = ST_EMIT;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rem_q   <= '0;
    end else begin
      state_q <= state_d;
      rem_q   <= rem_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    step_q  <= step_d;
    dec_q   <= dec_d;
    droot_q <= droot_d;
    minus_q <= minus_d;
    plus_q  <= plus_d;
    dlt_q   <= dlt_d;
    txs_q   <= txs_d;
    rxs_q   <= rxs_d;
    to_q    <= to_d;
    from_q  <= from_d;
    phase_q <= phase_d;
    txv_q   <= txv_d;
    rxv_q   <= rxv_d;
    err_q   <= err_d;
    total_q <= total_d;
  end

  // Channel outputs straight from registers.
  assign step_i.ready         = state_q == ST_IDLE;
  assign result_o.valid       = state_q == ST_EMIT;
  assign result_o.phase       = phase_q;
  assign result_o.to_peer     = to_q;
  assign result_o.from_peer   = from_q;
  assign result_o.tx_slice    = txv_q ? txs_q[nhr_pkg::IDX_W-1:0] : '0;
  assign result_o.rx_slice    = rxv_q ? rxs_q[nhr_pkg::IDX_W-1:0] : '0;
  assign result_o.tx_valid    = txv_q;
  assign result_o.rx_valid    = rxv_q;
  assign result_o.slice_total = total_q;
  assign result_o.is_last     = rem_q == TW'(1);
  assign result_o.error       = err_q;

endmodule

// ===== hdl/nhr_checker.sv =====
// ----------------------------------------------------------------------------
// Broadcast step schedule checker
// Port-level assertions on the step and result channels, bound to the top.
// ----------------------------------------------------------------------------
`include "nhr_broadcast_step_schedule_macros.svh"

module nhr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic                          out_is_last_i,
  input logic                          out_error_i,
  input logic                          out_tx_valid_i,
  input logic                          out_rx_valid_i,
  input logic [nhr_pkg::TOTAL_W-1:0]   out_slice_total_i,
  input logic [nhr_pkg::RANK_W-1:0]    out_to_peer_i,
  input logic [nhr_pkg::RANK_W-1:0]    out_from_peer_i
);

  // A new step is never taken while a result beat is pending.
  `NHR_ASSERT_NEVER(a_no_overlap, in_ready_i && out_valid_i, "step taken while busy")

  // An error beat is a lone final beat with no transfer.
  `NHR_ASSERT(a_err_beat, out_valid_i && out_error_i |-> out_is_last_i && !out_tx_valid_i && !out_rx_valid_i && (out_slice_total_i == '0), "malformed error beat")

  // After the final beat of a step the block returns to taking requests.
  `NHR_ASSERT(a_last_idle, out_valid_i && out_ready_i && out_is_last_i |=> !out_valid_i && in_ready_i, "no return to idle after last beat")

  // Within a step the peers and slice count stay fixed between beats.
  `NHR_ASSERT(a_step_const, out_valid_i && out_ready_i && !out_is_last_i |=> !in_ready_i && $stable(out_to_peer_i) && $stable(out_from_peer_i) && $stable(out_slice_total_i), "step fields changed between beats")

  // A stalled beat holds.
  `NHR_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_is_last_i), "stalled beat dropped")

endmodule

bind nhr_broadcast_step_schedule nhr_checker u_nhr_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (step_i.valid),
  .in_ready_i        (step_i.ready),
  .out_valid_i       (result_o.valid),
  .out_ready_i       (result_o.ready),
  .out_is_last_i     (result_o.is_last),
  .out_error_i       (result_o.error),
  .out_tx_valid_i    (result_o.tx_valid),
  .out_rx_valid_i    (result_o.rx_valid),
  .out_slice_total_i (result_o.slice_total),
  .out_to_peer_i     (result_o.to_peer),
  .out_from_peer_i   (result_o.from_peer)
);
